// File: rtl/pod_pkg.sv
package pod_pkg;

    localparam int POS_W      = 32;
    localparam int AXES       = 3;
    localparam int LIMB_W     = 32;
    localparam int PROD_W     = 64;
    localparam int NORM_W     = 66;
    localparam int SQ_W       = 132;
    localparam int ACC_W      = 192;
    localparam int N_PAD_W    = 96;
    localparam int E_PAD_W    = 160;
    localparam int SCALE_SH   = 30;
    localparam int T_W        = 16;
    localparam int T2_W       = 31;
    localparam int LIMIT_W    = 8;
    localparam int RUN_W      = 9;
    localparam int SEEN_W     = 2;
    localparam int PC_W       = 6;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0]    REPEAT_LIMIT_RST  = 8'd10;
    localparam logic signed [T_W-1:0] COS_THRESHOLD_RST = -16'sd29491;

    localparam logic [PC_W-1:0] PC_DONE = 6'd41;

    typedef enum logic [0:0] {
        CFG_REPEAT_LIMIT,
        CFG_COS_THRESHOLD
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MAC,
        OP_DIFF,
        OP_MOVL,
        OP_MOVE,
        OP_CMP,
        OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_MA,
        SRC_MB,
        SRC_D,
        SRC_NA,
        SRC_NB,
        SRC_E,
        SRC_T2,
        SRC_TMAG
    } src_t;

    // DST_DOT is resolved to DST_POS or DST_NEG by the sign of the axis product.
    typedef enum logic [2:0] {
        DST_NONE,
        DST_DOT,
        DST_POS,
        DST_NEG,
        DST_NA,
        DST_NB,
        DST_ACC,
        DST_T2
    } dst_t;

    typedef enum logic [1:0] {
        BR_NONE,
        BR_DEGEN,
        BR_SIGN
    } br_t;

    typedef struct packed {
        op_t        op;
        src_t       a_src;
        logic [2:0] a_idx;
        src_t       b_src;
        logic [2:0] b_idx;
        dst_t       dst;
        logic [2:0] shift;
        br_t        br;
    } ctrl_t;

    function automatic ctrl_t mac(src_t a, logic [2:0] ai, src_t b, logic [2:0] bi,
                                  dst_t d, logic [2:0] sh, br_t br);
        ctrl_t w;
        w.op    = OP_MAC;
        w.a_src = a;
        w.a_idx = ai;
        w.b_src = b;
        w.b_idx = bi;
        w.dst   = d;
        w.shift = sh;
        w.br    = br;
        return w;
    endfunction

    function automatic ctrl_t ctl(op_t op, br_t br);
        ctrl_t w;
        w.op    = op;
        w.a_src = SRC_ZERO;
        w.a_idx = 3'd0;
        w.b_src = SRC_ZERO;
        w.b_idx = 3'd0;
        w.dst   = DST_NONE;
        w.shift = 3'd0;
        w.br    = br;
        return w;
    endfunction

    // Control program. Every product is registered in prod_reg before it is added into its
    // destination, hence the NOP after each product group.
    function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            6'd0:  w = mac(SRC_TMAG, 3'd0, SRC_TMAG, 3'd0, DST_T2,  3'd0, BR_NONE);
            6'd1:  w = mac(SRC_MA,   3'd0, SRC_MB,   3'd0, DST_DOT, 3'd0, BR_NONE);
            6'd2:  w = mac(SRC_MA,   3'd0, SRC_MA,   3'd0, DST_NA,  3'd0, BR_NONE);
            6'd3:  w = mac(SRC_MB,   3'd0, SRC_MB,   3'd0, DST_NB,  3'd0, BR_NONE);
            6'd4:  w = mac(SRC_MA,   3'd1, SRC_MB,   3'd1, DST_DOT, 3'd0, BR_NONE);
            6'd5:  w = mac(SRC_MA,   3'd1, SRC_MA,   3'd1, DST_NA,  3'd0, BR_NONE);
            6'd6:  w = mac(SRC_MB,   3'd1, SRC_MB,   3'd1, DST_NB,  3'd0, BR_NONE);
            6'd7:  w = mac(SRC_MA,   3'd2, SRC_MB,   3'd2, DST_DOT, 3'd0, BR_NONE);
            6'd8:  w = mac(SRC_MA,   3'd2, SRC_MA,   3'd2, DST_NA,  3'd0, BR_NONE);
            6'd9:  w = mac(SRC_MB,   3'd2, SRC_MB,   3'd2, DST_NB,  3'd0, BR_NONE);
            6'd10: w = ctl(OP_NOP, BR_NONE);
            6'd11: w = ctl(OP_DIFF, BR_DEGEN);
            6'd12: w = mac(SRC_D, 3'd0, SRC_D, 3'd0, DST_ACC, 3'd0, BR_SIGN);
            6'd13: w = mac(SRC_D, 3'd0, SRC_D, 3'd1, DST_ACC, 3'd1, BR_NONE);
            6'd14: w = mac(SRC_D, 3'd0, SRC_D, 3'd2, DST_ACC, 3'd2, BR_NONE);
            6'd15: w = mac(SRC_D, 3'd1, SRC_D, 3'd0, DST_ACC, 3'd1, BR_NONE);
            6'd16: w = mac(SRC_D, 3'd1, SRC_D, 3'd1, DST_ACC, 3'd2, BR_NONE);
            6'd17: w = mac(SRC_D, 3'd1, SRC_D, 3'd2, DST_ACC, 3'd3, BR_NONE);
            6'd18: w = mac(SRC_D, 3'd2, SRC_D, 3'd0, DST_ACC, 3'd2, BR_NONE);
            6'd19: w = mac(SRC_D, 3'd2, SRC_D, 3'd1, DST_ACC, 3'd3, BR_NONE);
            6'd20: w = mac(SRC_D, 3'd2, SRC_D, 3'd2, DST_ACC, 3'd4, BR_NONE);
            6'd21: w = ctl(OP_NOP, BR_NONE);
            6'd22: w = ctl(OP_MOVL, BR_NONE);
            6'd23: w = mac(SRC_NA, 3'd0, SRC_NB, 3'd0, DST_ACC, 3'd0, BR_NONE);
            6'd24: w = mac(SRC_NA, 3'd0, SRC_NB, 3'd1, DST_ACC, 3'd1, BR_NONE);
            6'd25: w = mac(SRC_NA, 3'd0, SRC_NB, 3'd2, DST_ACC, 3'd2, BR_NONE);
            6'd26: w = mac(SRC_NA, 3'd1, SRC_NB, 3'd0, DST_ACC, 3'd1, BR_NONE);
            6'd27: w = mac(SRC_NA, 3'd1, SRC_NB, 3'd1, DST_ACC, 3'd2, BR_NONE);
            6'd28: w = mac(SRC_NA, 3'd1, SRC_NB, 3'd2, DST_ACC, 3'd3, BR_NONE);
            6'd29: w = mac(SRC_NA, 3'd2, SRC_NB, 3'd0, DST_ACC, 3'd2, BR_NONE);
            6'd30: w = mac(SRC_NA, 3'd2, SRC_NB, 3'd1, DST_ACC, 3'd3, BR_NONE);
            6'd31: w = mac(SRC_NA, 3'd2, SRC_NB, 3'd2, DST_ACC, 3'd4, BR_NONE);
            6'd32: w = ctl(OP_NOP, BR_NONE);
            6'd33: w = ctl(OP_MOVE, BR_NONE);
            6'd34: w = mac(SRC_T2, 3'd0, SRC_E, 3'd0, DST_ACC, 3'd0, BR_NONE);
            6'd35: w = mac(SRC_T2, 3'd0, SRC_E, 3'd1, DST_ACC, 3'd1, BR_NONE);
            6'd36: w = mac(SRC_T2, 3'd0, SRC_E, 3'd2, DST_ACC, 3'd2, BR_NONE);
            6'd37: w = mac(SRC_T2, 3'd0, SRC_E, 3'd3, DST_ACC, 3'd3, BR_NONE);
            6'd38: w = mac(SRC_T2, 3'd0, SRC_E, 3'd4, DST_ACC, 3'd4, BR_NONE);
            6'd39: w = ctl(OP_NOP, BR_NONE);
            6'd40: w = ctl(OP_CMP, BR_NONE);
            default: w = ctl(OP_DONE, BR_NONE);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pose_oscillation_detector.sv
// The first two positions of a run jump to the final control step, which registers
// their result word once the output is free; no new word is taken until then.
// A position that closes a step pair runs the 42-word control program on one shared
// 32x32 multiplier; it ends early at the difference step when a step has zero length,
// or at the first squared-difference product when the dot product sign alone decides.
// Reset (rst_n low, asynchronous) clears the run state and loads limit 10, threshold -0.9.
module pose_oscillation_detector
    import pod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z
    input  logic                  s_tuser,   // run_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // oscillation_found, step_inverted, zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                  state_reg;
    logic [PC_W-1:0]         pc_reg;
    logic [SEEN_W-1:0]       seen_reg;
    logic                    pair_reg;
    logic                    last_inv_reg;
    logic [RUN_W-1:0]        run_reg;
    logic                    found_reg;
    logic                    m_tvalid_reg;
    logic                    out_found_reg;
    logic                    out_inv_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic signed [T_W-1:0]   thr_reg;
    dst_t                    pend_dst_reg;

    logic [POS_W-1:0]        last_pos_reg  [AXES];
    logic [POS_W-1:0]        older_pos_reg [AXES];
    logic [2:0][LIMB_W-1:0]  ma_reg;
    logic [2:0][LIMB_W-1:0]  mb_reg;
    logic [AXES-1:0]         sd_reg;
    logic [NORM_W-1:0]       pos_reg;
    logic [NORM_W-1:0]       neg_reg;
    logic [NORM_W-1:0]       na_reg;
    logic [NORM_W-1:0]       nb_reg;
    logic [NORM_W-1:0]       d_reg;
    logic                    dneg_reg;
    logic [SQ_W-1:0]         l_reg;
    logic [SQ_W-1:0]         e_reg;
    logic [T2_W-1:0]         t2_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [2:0]              pend_sh_reg;
    logic                    inv_reg;

    ctrl_t                   cw;
    logic                    in_fire;
    logic                    run_en;
    logic                    out_free;
    logic                    done_fire;
    logic [SEEN_W-1:0]       seen_eff;
    logic                    t_pos;
    logic                    t_npos;
    logic                    degen;
    logic                    take_branch;
    logic                    hit;
    logic [T_W-1:0]          tmag;
    logic [2:0][LIMB_W-1:0]  d_limb;
    logic [2:0][LIMB_W-1:0]  na_limb;
    logic [2:0][LIMB_W-1:0]  nb_limb;
    logic [4:0][LIMB_W-1:0]  e_limb;
    logic [LIMB_W-1:0]       op_a;
    logic [LIMB_W-1:0]       op_b;
    dst_t                    dst_issue;
    logic [ACC_W-1:0]        lhs;
    logic [POS_W:0]          diff_a [AXES];
    logic [POS_W:0]          diff_b [AXES];

    function automatic logic [LIMB_W-1:0] limb3(logic [2:0][LIMB_W-1:0] v, logic [2:0] i);
        logic [LIMB_W-1:0] r;
        unique case (i)
            3'd0:    r = v[0];
            3'd1:    r = v[1];
            3'd2:    r = v[2];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [LIMB_W-1:0] limb5(logic [4:0][LIMB_W-1:0] v, logic [2:0] i);
        logic [LIMB_W-1:0] r;
        unique case (i)
            3'd0:    r = v[0];
            3'd1:    r = v[1];
            3'd2:    r = v[2];
            3'd3:    r = v[3];
            3'd4:    r = v[4];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [LIMB_W-1:0] operand(
        src_t s, logic [2:0] i,
        logic [2:0][LIMB_W-1:0] ma, logic [2:0][LIMB_W-1:0] mb,
        logic [2:0][LIMB_W-1:0] dl, logic [2:0][LIMB_W-1:0] nal,
        logic [2:0][LIMB_W-1:0] nbl, logic [4:0][LIMB_W-1:0] el,
        logic [T2_W-1:0] t2, logic [T_W-1:0] tm);
        logic [LIMB_W-1:0] r;
        unique case (s)
            SRC_MA:   r = limb3(ma, i);
            SRC_MB:   r = limb3(mb, i);
            SRC_D:    r = limb3(dl, i);
            SRC_NA:   r = limb3(nal, i);
            SRC_NB:   r = limb3(nbl, i);
            SRC_E:    r = limb5(el, i);
            SRC_T2:   r = LIMB_W'(t2);
            SRC_TMAG: r = LIMB_W'(tm);
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign cw        = ucode(pc_reg);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'b0, out_inv_reg, out_found_reg};

    assign in_fire   = s_tvalid && s_tready;
    assign run_en    = (state_reg == S_RUN);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_fire = run_en && (cw.op == OP_DONE) && out_free;
    assign seen_eff  = s_tuser ? '0 : seen_reg;

    assign t_pos  = !thr_reg[T_W-1] && (thr_reg != '0);
    assign t_npos = thr_reg[T_W-1] || (thr_reg == '0);
    assign degen  = (na_reg == '0) || (nb_reg == '0);
    assign tmag   = thr_reg[T_W-1] ? T_W'(-thr_reg) : T_W'(thr_reg);

    // A zero-length step decides by the threshold sign; otherwise the dot product
    // sign decides when the threshold is zero or when the two signs disagree.
    assign take_branch = run_en
        && (((cw.br == BR_DEGEN) && degen)
            || ((cw.br == BR_SIGN)
                && ((dneg_reg && !thr_reg[T_W-1]) || (!dneg_reg && t_npos))));

    assign hit = pair_reg && last_inv_reg && inv_reg && (run_reg > {1'b0, limit_reg});

    assign d_limb  = N_PAD_W'(d_reg);
    assign na_limb = N_PAD_W'(na_reg);
    assign nb_limb = N_PAD_W'(nb_reg);
    assign e_limb  = E_PAD_W'(e_reg);

    assign op_a = operand(cw.a_src, cw.a_idx, ma_reg, mb_reg, d_limb, na_limb, nb_limb,
                          e_limb, t2_reg, tmag);
    assign op_b = operand(cw.b_src, cw.b_idx, ma_reg, mb_reg, d_limb, na_limb, nb_limb,
                          e_limb, t2_reg, tmag);

    assign dst_issue = (cw.dst == DST_DOT) ? (sd_reg[cw.a_idx[1:0]] ? DST_NEG : DST_POS)
                                           : cw.dst;

    assign lhs = ACC_W'({l_reg, {SCALE_SH{1'b0}}});

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            diff_a[k] = {last_pos_reg[k][POS_W-1], last_pos_reg[k]}
                      - {older_pos_reg[k][POS_W-1], older_pos_reg[k]};
            diff_b[k] = {s_tdata[POS_W*k+POS_W-1], s_tdata[POS_W*k +: POS_W]}
                      - {last_pos_reg[k][POS_W-1], last_pos_reg[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            seen_reg      <= '0;
            pair_reg      <= 1'b0;
            last_inv_reg  <= 1'b0;
            run_reg       <= '0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            out_found_reg <= 1'b0;
            out_inv_reg   <= 1'b0;
            limit_reg     <= REPEAT_LIMIT_RST;
            thr_reg       <= COS_THRESHOLD_RST;
            pend_dst_reg  <= DST_NONE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_REPEAT_LIMIT:  limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_COS_THRESHOLD: thr_reg   <= cfg_data;
                endcase
            end

            if (m_tvalid_reg && m_tready && !done_fire)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (in_fire)
            begin
                state_reg    <= S_RUN;
                pair_reg     <= seen_eff[1];
                pc_reg       <= seen_eff[1] ? '0 : PC_DONE;
                seen_reg     <= seen_eff[1] ? seen_eff : SEEN_W'(seen_eff + 2'd1);
                pend_dst_reg <= DST_NONE;
                if (s_tuser)
                begin
                    last_inv_reg <= 1'b0;
                    run_reg      <= '0;
                    found_reg    <= 1'b0;
                end
            end
            else if (run_en)
            begin
                pend_dst_reg <= (cw.op == OP_MAC) ? dst_issue : DST_NONE;
                if (cw.op == OP_DONE)
                begin
                    if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        m_tvalid_reg  <= 1'b1;
                        out_found_reg <= found_reg || hit;
                        out_inv_reg   <= pair_reg && inv_reg;
                        if (pair_reg)
                        begin
                            last_inv_reg <= inv_reg;
                            if (last_inv_reg && inv_reg)
                            begin
                                if (run_reg > {1'b0, limit_reg})
                                begin
                                    found_reg <= 1'b1;
                                end
                                else
                                begin
                                    run_reg <= RUN_W'(run_reg + 9'd1);
                                end
                            end
                            else
                            begin
                                run_reg <= '0;
                            end
                        end
                    end
                end
                else
                begin
                    pc_reg <= take_branch ? PC_DONE : PC_W'(pc_reg + 6'd1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                ma_reg[k]        <= diff_a[k][POS_W] ? POS_W'(-diff_a[k]) : diff_a[k][POS_W-1:0];
                mb_reg[k]        <= diff_b[k][POS_W] ? POS_W'(-diff_b[k]) : diff_b[k][POS_W-1:0];
                sd_reg[k]        <= diff_a[k][POS_W] ^ diff_b[k][POS_W];
                older_pos_reg[k] <= last_pos_reg[k];
                last_pos_reg[k]  <= s_tdata[POS_W*k +: POS_W];
            end
            pos_reg <= '0;
            neg_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            acc_reg <= '0;
            inv_reg <= 1'b0;
        end
        else if (run_en)
        begin
            if (cw.op == OP_MAC)
            begin
                prod_reg    <= PROD_W'(op_a) * PROD_W'(op_b);
                pend_sh_reg <= cw.shift;
            end

            unique case (pend_dst_reg)
                DST_POS: pos_reg <= pos_reg + NORM_W'(prod_reg);
                DST_NEG: neg_reg <= neg_reg + NORM_W'(prod_reg);
                DST_NA:  na_reg  <= na_reg + NORM_W'(prod_reg);
                DST_NB:  nb_reg  <= nb_reg + NORM_W'(prod_reg);
                DST_ACC: acc_reg <= acc_reg + (ACC_W'(prod_reg) << {pend_sh_reg, 5'b0});
                DST_T2:  t2_reg  <= prod_reg[T2_W-1:0];
                default: ;
            endcase

            unique case (cw.op)
                OP_DIFF:
                begin
                    dneg_reg <= (neg_reg > pos_reg);
                    d_reg    <= (neg_reg > pos_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;
                end
                OP_MOVL:
                begin
                    l_reg   <= acc_reg[SQ_W-1:0];
                    acc_reg <= '0;
                end
                OP_MOVE:
                begin
                    e_reg   <= acc_reg[SQ_W-1:0];
                    acc_reg <= '0;
                end
                // Squared cosine test: dot^2 * 2^30 against T^2 * |a|^2 * |b|^2.
                OP_CMP:  inv_reg <= dneg_reg ? (lhs > acc_reg) : (lhs < acc_reg);
                default: ;
            endcase

            if (take_branch)
            begin
                inv_reg <= (cw.br == BR_DEGEN) ? t_pos : dneg_reg;
            end
        end
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_en |-> (pc_reg <= PC_DONE))
        else $error("control program counter left the program");

    a_run_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser) |=> !found_reg)
        else $error("run start did not clear the detected flag");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && !(in_fire && s_tuser)) |=> found_reg)
        else $error("detected flag dropped within a run");

    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (pend_dst_reg == DST_NONE))
        else $error("product still pending while idle");

    a_short_item_not_inverted: assert property (@(posedge clk) disable iff (!rst_n)
        (done_fire && !pair_reg) |=> !m_tdata[1])
        else $error("inversion reported without a step pair");

endmodule

// File: dv/pod_checker.sv
`timescale 1ns / 1ps

module pod_checker
    import pod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z
    input  logic                  s_tuser,   // run_start
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // oscillation_found, step_inverted, zero pad
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int QDEPTH = 16;

    typedef logic [IN_DATA_W-1:0] point_t;

    typedef struct packed {
        logic found;
        logic inverted;
    } verdict_t;

    verdict_t verdict_mem [QDEPTH];

    logic [3:0]            wr_idx;
    logic [3:0]            rd_idx;
    int                    held;
    logic [LIMIT_W-1:0]    limit_r;
    logic signed [T_W-1:0] thr_r;
    point_t                last_pt;
    point_t                older_pt;
    logic [SEEN_W-1:0]     seen;
    logic                  prev_inv;
    logic [RUN_W-1:0]      inv_run;
    logic                  found;
    logic                  inv;
    verdict_t              want;
    int                    fails;

    // Exact test of cos(prev step, current step) < thr / 2^15, done on squares so that
    // nothing is rounded.
    function automatic logic reverses(point_t older, point_t last, point_t cur,
                                      logic signed [T_W-1:0] thr);
        logic signed [POS_W+1:0] a;
        logic signed [POS_W+1:0] b;
        logic signed [67:0]      dot;
        logic signed [67:0]      na2;
        logic signed [67:0]      nb2;
        logic signed [67:0]      dmag;
        logic signed [31:0]      t2;
        logic [ACC_W-1:0]        d_w;
        logic [ACC_W-1:0]        na_w;
        logic [ACC_W-1:0]        nb_w;
        logic [ACC_W-1:0]        t2_w;
        logic [ACC_W-1:0]        lhs;
        logic [ACC_W-1:0]        rhs;
        logic                    dneg;
        dot = '0;
        na2 = '0;
        nb2 = '0;
        for (int k = 0; k < AXES; k++)
        begin
            a = (POS_W+2)'($signed(last[k*POS_W +: POS_W]))
              - (POS_W+2)'($signed(older[k*POS_W +: POS_W]));
            b = (POS_W+2)'($signed(cur[k*POS_W +: POS_W]))
              - (POS_W+2)'($signed(last[k*POS_W +: POS_W]));
            dot = dot + 68'(a) * 68'(b);
            na2 = na2 + 68'(a) * 68'(a);
            nb2 = nb2 + 68'(b) * 68'(b);
        end
        // A zero-length step counts as cosine 0.
        if (na2 == 0 || nb2 == 0)
            return thr > 0;
        dneg = dot < 0;
        if (dneg && thr >= 0)
            return 1'b1;
        if (!dneg && thr <= 0)
            return 1'b0;
        dmag = dneg ? -dot : dot;
        t2   = 32'(thr) * 32'(thr);
        d_w  = ACC_W'(dmag);
        na_w = ACC_W'(na2);
        nb_w = ACC_W'(nb2);
        t2_w = ACC_W'(t2);
        lhs  = (d_w * d_w) << SCALE_SH;
        rhs  = t2_w * na_w * nb_w;
        return dneg ? (lhs > rhs) : (lhs < rhs);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_r  = REPEAT_LIMIT_RST;
            thr_r    = COS_THRESHOLD_RST;
            last_pt  = '0;
            older_pt = '0;
            seen     = '0;
            prev_inv = 1'b0;
            inv_run  = '0;
            found    = 1'b0;
            fails    = 0;
            wr_idx   = '0;
            rd_idx   = '0;
            held     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_REPEAT_LIMIT)
                    limit_r = cfg_data[LIMIT_W-1:0];
                else
                    thr_r = cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    seen     = '0;
                    prev_inv = 1'b0;
                    inv_run  = '0;
                    found    = 1'b0;
                end
                inv = 1'b0;
                if (seen >= 2)
                begin
                    inv = reverses(older_pt, last_pt, s_tdata, thr_r);
                    if (prev_inv && inv)
                    begin
                        if (inv_run > limit_r)
                            found = 1'b1;
                        else
                            inv_run = inv_run + 1'b1;
                    end
                    else
                        inv_run = '0;
                    prev_inv = inv;
                end
                else
                    seen = seen + 1'b1;
                older_pt = last_pt;
                last_pt  = s_tdata;
                if (held == QDEPTH)
                begin
                    $display("%0t: more than %0d result words outstanding", $time, QDEPTH);
                    fails++;
                end
                else
                begin
                    verdict_mem[wr_idx] = '{found: found, inverted: inv};
                    wr_idx = wr_idx + 1'b1;
                    held++;
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (held == 0)
                begin
                    $display("%0t: result word %b arrived with no position outstanding",
                             $time, m_tdata);
                    fails++;
                end
                else
                begin
                    want   = verdict_mem[rd_idx];
                    rd_idx = rd_idx + 1'b1;
                    held--;
                    if (m_tdata[0] !== want.found)
                    begin
                        $display("%0t: oscillation_found expected %b actual %b",
                                 $time, want.found, m_tdata[0]);
                        fails++;
                    end
                    if (m_tdata[1] !== want.inverted)
                    begin
                        $display("%0t: step_inverted expected %b actual %b",
                                 $time, want.inverted, m_tdata[1]);
                        fails++;
                    end
                end
            end

            fail_count <= fails;
            pending    <= held;
        end
    end

endmodule

// File: dv/pose_oscillation_detector_tb.sv
`timescale 1ns / 1ps

module pose_oscillation_detector_tb;
    import pod_pkg::*;

    typedef logic signed [POS_W-1:0] coord_t;

    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN       = 60;
    localparam int     CYCLE_LIMIT = 800000;
    localparam coord_t CMAX        = 32'sh7FFF_FFFF;
    localparam coord_t CMIN        = 32'sh8000_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int hold_asks;
    int holds_done;
    int send_left;
    bit send_lazy;
    int cur_limit;
    int phase_words;
    int got;

    pose_oscillation_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pod_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one position word; valid stays high afterwards so that back-to-back words
    // need no second assignment in the same step.
    task automatic offer(input coord_t x, input coord_t y, input coord_t z, input logic st);
        int gap;
        if (send_left == 0)
        begin
            send_left = $urandom_range(20, 80);
            send_lazy = $urandom_range(0, 2) != 0;
        end
        send_left--;
        gap = send_lazy ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= st;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [LIMIT_W-1:0] lim, input logic signed [T_W-1:0] thr);
        settle();
        cur_limit = int'(lim);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_REPEAT_LIMIT;
        cfg_data  <= CFG_DATA_W'(lim);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_COS_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One run of positions. Most runs bounce between two points so that inversions
    // chain up and the detector gets a chance to trip.
    task automatic random_run(input bit long_osc, output int count);
        int          kind;
        int          len;
        int unsigned sc;
        int unsigned jc;
        coord_t      bx, by, bz;
        coord_t      dx, dy, dz;
        coord_t      px, py, pz;
        logic        st;
        kind = long_osc ? 0 : $urandom_range(0, 9);
        st   = $urandom_range(0, 7) != 0;
        if ($urandom_range(0, 1))
        begin
            bx = $urandom();
            by = $urandom();
            bz = $urandom();
        end
        else
        begin
            bx = $urandom_range(0, 8191) - 4096;
            by = $urandom_range(0, 8191) - 4096;
            bz = $urandom_range(0, 8191) - 4096;
        end
        sc = 1 << $urandom_range(4, 30);
        jc = sc >> $urandom_range(2, 10);
        dx = $urandom_range(0, 2 * sc) - sc;
        dy = $urandom_range(0, 2 * sc) - sc;
        dz = $urandom_range(0, 2 * sc) - sc;
        px = bx;
        py = by;
        pz = bz;
        if (kind <= 5)
            len = (long_osc || $urandom_range(0, 4) == 0) ? cur_limit + $urandom_range(4, 12)
                                                          : $urandom_range(3, 25);
        else if (kind == 9)
            len = $urandom_range(1, 2);
        else
            len = $urandom_range(3, 20);
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                6:
                begin
                    px = px + dx + coord_t'($urandom_range(0, 2 * jc) - jc);
                    py = py + dy + coord_t'($urandom_range(0, 2 * jc) - jc);
                    pz = pz + dz + coord_t'($urandom_range(0, 2 * jc) - jc);
                end
                7, 9:
                begin
                    px = $urandom();
                    py = $urandom();
                    pz = $urandom();
                end
                8:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        px = px + coord_t'($urandom_range(0, 64) - 32);
                        py = py + coord_t'($urandom_range(0, 64) - 32);
                    end
                end
                default:
                begin
                    px = bx + coord_t'($urandom_range(0, 2 * jc) - jc);
                    py = by + coord_t'($urandom_range(0, 2 * jc) - jc);
                    pz = bz + coord_t'($urandom_range(0, 2 * jc) - jc);
                    if (k % 2 == 1)
                    begin
                        px = px + dx;
                        py = py + dy;
                        pz = pz + dz;
                    end
                end
            endcase
            offer(px, py, pz, st && k == 0);
        end
        count = len;
    endtask

    // Result side: random ready gaps in stretches, plus one long hold when asked.
    initial
    begin
        int gap;
        int left;
        bit lazy;
        m_tready <= 1'b0;
        left = 0;
        lazy = 1'b0;
        holds_done = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (holds_done != hold_asks)
            begin
                holds_done = hold_asks;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0)
            begin
                left = $urandom_range(20, 80);
                lazy = $urandom_range(0, 2) != 0;
            end
            left--;
            gap = lazy ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_REPEAT_LIMIT;
        cfg_data  <= '0;
        hold_asks = 0;
        send_left = 0;
        cur_limit = int'(REPEAT_LIMIT_RST);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state acts as an open run: no start flag on the first words.
        offer(0, 0, 0, 1'b0);
        offer(1024, 0, 0, 1'b0);
        offer(0, 0, 0, 1'b0);
        offer(1024, 0, 0, 1'b0);
        offer(1024, 0, 0, 1'b0);
        offer(1024, 0, 0, 1'b0);
        // Full-scale swings between the corners of the coordinate range.
        offer(CMIN, CMIN, CMIN, 1'b1);
        offer(CMAX, CMAX, CMAX, 1'b0);
        offer(CMIN, CMIN, CMIN, 1'b0);
        offer(CMAX, CMAX, CMAX, 1'b0);
        offer(CMIN, CMAX, CMIN, 1'b0);
        offer(CMAX, CMIN, CMAX, 1'b0);
        offer(5, -5, 7, 1'b1);
        offer(5, -5, 7, 1'b0);
        offer(100, 3, -2, 1'b0);

        // Positive threshold: zero-length steps count as inversions and trip the detector.
        configure(8'd0, 16'sd32767);
        offer(0, 0, 0, 1'b1);
        offer(0, 0, 0, 1'b0);
        offer(0, 0, 0, 1'b0);
        offer(0, 0, 0, 1'b0);
        offer(0, 0, 0, 1'b0);
        offer(10, 0, 0, 1'b1);
        offer(10, 10, 0, 1'b0);
        offer(20, 10, 0, 1'b0);

        configure(8'd0, 16'sd0);
        offer(0, 0, 0, 1'b1);
        offer(10, 0, 0, 1'b0);
        offer(10, 10, 0, 1'b0);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: configure(8'd0, COS_THRESHOLD_RST);
                1: configure(8'd255, COS_THRESHOLD_RST);
                2: configure(8'd3, 16'sd0);
                3: configure(8'd1, 16'sd32767);
                4: configure(LIMIT_W'($urandom_range(0, 20)), -16'sd32768);
                5: configure(8'd2, T_W'($urandom_range(0, 65535)));
                6: configure(8'd10, 16'sd16384);
                7: configure(LIMIT_W'($urandom_range(0, 255)), -16'sd31000);
                default: configure(LIMIT_W'($urandom_range(0, 15)),
                                   T_W'($urandom_range(0, 65535)));
            endcase
            if (ph == 3)
                hold_asks++;
            phase_words = 0;
            if (ph == 1)
            begin
                random_run(1'b1, got);
                phase_words += got;
            end
            while (phase_words < 175)
            begin
                random_run(1'b0, got);
                phase_words += got;
            end
        end

        settle();
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/pod_pkg.sv
rtl/pose_oscillation_detector.sv
dv/pod_checker.sv
dv/pose_oscillation_detector_tb.sv
